>>> hw/rtl/pea_pkg.sv
// ----------------------------------------------------------------------------
// pea_pkg
// shared types, codes and reset values of the pen event aggregator
// ----------------------------------------------------------------------------
package pea_pkg;

  // event types
  localparam logic [4:0] EV_SYN = 5'd0;
  localparam logic [4:0] EV_KEY = 5'd1;
  localparam logic [4:0] EV_ABS = 5'd3;

  // event codes
  localparam logic [9:0] CODE_X        = 10'd0;
  localparam logic [9:0] CODE_Y        = 10'd1;
  localparam logic [9:0] CODE_PRESSURE = 10'd24;
  localparam logic [9:0] CODE_TILT_X   = 10'd26;
  localparam logic [9:0] CODE_TILT_Y   = 10'd27;
  localparam logic [9:0] CODE_PEN      = 10'd320;
  localparam logic [9:0] CODE_ERASER   = 10'd321;
  localparam logic [9:0] CODE_TOUCH    = 10'd330;
  localparam logic [9:0] CODE_REPORT   = 10'd0;

  // result kinds
  localparam logic [2:0] KIND_ENTER   = 3'd0;
  localparam logic [2:0] KIND_MOVE    = 3'd1;
  localparam logic [2:0] KIND_PRESS   = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_LEAVE   = 3'd4;

  // tools
  localparam logic [1:0] TOOL_NONE   = 2'd0;
  localparam logic [1:0] TOOL_PEN    = 2'd1;
  localparam logic [1:0] TOOL_ERASER = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MAX_X      = 3'd0;
  localparam logic [2:0] REG_MAX_Y      = 3'd1;
  localparam logic [2:0] REG_MAX_PRES   = 3'd2;
  localparam logic [2:0] REG_TILT_MIN_X = 3'd3;
  localparam logic [2:0] REG_TILT_MAX_X = 3'd4;
  localparam logic [2:0] REG_TILT_MIN_Y = 3'd5;
  localparam logic [2:0] REG_TILT_MAX_Y = 3'd6;

  // register reset values
  localparam logic [15:0] RST_MAX_X    = 16'd20967;
  localparam logic [15:0] RST_MAX_Y    = 16'd15725;
  localparam logic [15:0] RST_MAX_PRES = 16'd4095;
  localparam logic [15:0] RST_TILT_MIN = 16'hDCD8; // -9000
  localparam logic [15:0] RST_TILT_MAX = 16'h2328; // 9000

  localparam logic [4:0] PREV_TYPE_RST = 5'd31;

  // scaling operations, one per divider pass
  localparam logic [2:0] OP_POS_X  = 3'd0;
  localparam logic [2:0] OP_POS_Y  = 3'd1;
  localparam logic [2:0] OP_PRES   = 3'd2;
  localparam logic [2:0] OP_TILT_X = 3'd3;
  localparam logic [2:0] OP_TILT_Y = 3'd4;

  localparam int DEF_SCREEN_WIDTH  = 1404;
  localparam int DEF_SCREEN_HEIGHT = 1872;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_COMMIT,
    ST_EMIT_ENTER,
    ST_EMIT_MID,
    ST_EMIT_LEAVE
  } state_t;

  typedef struct packed {
    logic       ev_latch;
    logic       rep_start;
    logic [2:0] op;
    logic       mul_load;
    logic       div_start;
    logic       res_store;
    logic       rep_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       is_report;
    logic       div_done;
    logic       has_enter;
    logic       has_leave;
    logic [2:0] mid_kind;
  } ctrl_status_t;

endpackage

>>> hw/rtl/pen_event_aggregator.sv
// ----------------------------------------------------------------------------
// pen_event_aggregator
// turns raw pen events into enter, press, release, move and leave results
// ----------------------------------------------------------------------------
// latency: axis, key and ignored events are taken one per cycle, back to back
// a sync report runs five passes (multiply, divider load, 16 divider steps,
// quotient store) plus a commit; the passes share one 16-step restoring
// divider; one to three result beats follow and events are held off until
// the last beat is taken
// reset clears latched axes and report state and loads the register defaults
module pen_event_aggregator #(
  parameter int SCREEN_WIDTH  = pea_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pea_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  // event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // event_code[9:0], event_value[41:10], zero fill
  input  logic [4:0]  s_axis_tuser,  // event_type[4:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // pos_x[15:0], pos_y[31:16], pointer[33:32],
                                     // pressure[49:34], tilt_x[57:50], tilt_y[65:58],
                                     // button_down[66], zero fill
  output logic [2:0]  m_axis_tuser,  // kind[2:0]
  output logic        m_axis_tlast,  // final beat of a report
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  pea_pkg::ctrl_cmd_t    cmd;
  pea_pkg::ctrl_status_t status;

  logic [15:0] pos_x, pos_y, pressure;
  logic [1:0]  pointer;
  logic [7:0]  tilt_x, tilt_y;
  logic        button_down;

  // registers are taken only while idle, never while a report is in flight
  assign cfg_ready = s_axis_tready;

  pea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .kind      (m_axis_tuser),
    .last      (m_axis_tlast),
    .cmd       (cmd),
    .status    (status)
  );

  pea_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .ev_type     (s_axis_tuser),
    .ev_code     (s_axis_tdata[9:0]),
    .ev_value    (s_axis_tdata[41:10]),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pointer     (pointer),
    .pressure    (pressure),
    .tilt_x      (tilt_x),
    .tilt_y      (tilt_y),
    .button_down (button_down)
  );

  // result payload is held in datapath registers for the whole report
  assign m_axis_tdata = {5'd0, button_down, tilt_y, tilt_x, pressure, pointer, pos_y, pos_x};

endmodule

>>> hw/rtl/pea_div.sv
// ----------------------------------------------------------------------------
// pea_div
// restoring divider, one quotient bit per cycle, 16-bit quotient with overflow
// ----------------------------------------------------------------------------
module pea_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [49:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic        ovf,
  output logic [15:0] quot
);

  logic [15:0] rem;
  logic [15:0] low;
  logic [15:0] dsr;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, low[15]};
  assign fits  = trial >= {1'b0, dsr};
  assign quot  = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient fits 16 bits only when the upper part is below the divisor
      ovf <= num[49:16] >= {18'd0, den};
      rem <= num[31:16];
      low <= num[15:0];
      dsr <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= 16'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[15:0];
      end
      low <= {low[14:0], fits};
    end
  end

endmodule

>>> hw/rtl/pea_datapath.sv
// ----------------------------------------------------------------------------
// pea_datapath
// event state, configuration, scaling multiplier, divider and result registers
// ----------------------------------------------------------------------------
module pea_datapath #(
  parameter int SCREEN_WIDTH  = pea_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pea_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pea_pkg::ctrl_cmd_t    cmd,
  output pea_pkg::ctrl_status_t status,
  input  logic [4:0]            ev_type,
  input  logic [9:0]            ev_code,
  input  logic [31:0]           ev_value,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output logic [15:0]           pos_x,
  output logic [15:0]           pos_y,
  output logic [1:0]            pointer,
  output logic [15:0]           pressure,
  output logic [7:0]            tilt_x,
  output logic [7:0]            tilt_y,
  output logic                  button_down
);

  localparam logic [16:0] MULT_X    = 17'(SCREEN_WIDTH * 16);
  localparam logic [16:0] MULT_Y    = 17'(SCREEN_HEIGHT * 16);
  localparam logic [16:0] MULT_PRES = 17'h10000;
  localparam logic [16:0] MULT_TILT = 17'd180;

  logic [15:0] max_x, max_y, max_pres;
  logic [15:0] tmin_x, tmax_x, tmin_y, tmax_y;

  logic [31:0] raw_x, raw_y, raw_pres, raw_tx, raw_ty;
  logic        touching;
  logic [1:0]  tool_now;
  logic        rep_down;
  logic [1:0]  rep_tool;
  logic [15:0] rep_pos_x, rep_pos_y;
  logic [4:0]  prev_type;

  logic        has_enter, has_leave, releasing;
  logic [2:0]  mid_kind;

  logic [15:0] calc_x, calc_y;

  // operand selection
  logic [32:0] mag;
  logic [16:0] mult;
  logic [15:0] den;
  logic        zero_res, tilt_neg, tilt_zden, is_tilt;
  logic [31:0] sel_raw;
  logic [15:0] sel_max, sel_lo, sel_hi;
  logic [32:0] diff;
  logic [16:0] tden;

  logic [49:0] prod;
  logic [15:0] den_q;
  logic        zero_q, neg_q, zden_q, tilt_q;

  logic        div_done, div_ovf;
  logic [15:0] quot;
  logic [15:0] u_res;
  logic [7:0]  t_res;

  always_comb begin
    sel_raw = raw_x;
    sel_max = max_x;
    sel_lo  = tmin_y;
    sel_hi  = tmax_y;
    mult    = MULT_X;
    is_tilt = 1'b0;
    case (cmd.op)
      pea_pkg::OP_POS_X: begin
        sel_raw = raw_x;
        sel_max = max_x;
        mult    = MULT_X;
      end
      pea_pkg::OP_POS_Y: begin
        sel_raw = raw_y;
        sel_max = max_y;
        mult    = MULT_Y;
      end
      pea_pkg::OP_PRES: begin
        sel_raw = raw_pres;
        sel_max = max_pres;
        mult    = MULT_PRES;
      end
      pea_pkg::OP_TILT_X: begin
        // horizontal output comes from the vertical raw axis
        sel_raw = raw_ty;
        sel_lo  = tmin_y;
        sel_hi  = tmax_y;
        mult    = MULT_TILT;
        is_tilt = 1'b1;
      end
      default: begin
        sel_raw = raw_tx;
        sel_lo  = tmin_x;
        sel_hi  = tmax_x;
        mult    = MULT_TILT;
        is_tilt = 1'b1;
      end
    endcase

    diff = {sel_raw[31], sel_raw} - {{17{sel_lo[15]}}, sel_lo};
    tden = {sel_hi[15], sel_hi} - {sel_lo[15], sel_lo};

    if (is_tilt) begin
      mag       = diff[32] ? 33'(-diff) : diff;
      den       = tden[16] ? 16'(-tden) : tden[15:0];
      tilt_neg  = diff[32] ^ tden[16];
      tilt_zden = tden == 17'd0;
      zero_res  = 1'b0;
    end else begin
      mag       = {2'b00, sel_raw[30:0]};
      den       = (sel_max == 16'd0) ? 16'd1 : sel_max;
      tilt_neg  = 1'b0;
      tilt_zden = 1'b0;
      zero_res  = sel_raw[31] || (sel_raw == 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod   <= mag * mult;
      den_q  <= (den == 16'd0) ? 16'd1 : den;
      zero_q <= zero_res;
      neg_q  <= tilt_neg;
      zden_q <= tilt_zden;
      tilt_q <= is_tilt;
    end
  end

  pea_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod),
    .den   (den_q),
    .done  (div_done),
    .ovf   (div_ovf),
    .quot  (quot)
  );

  always_comb begin
    if (zero_q) begin
      u_res = 16'd0;
    end else if (div_ovf) begin
      u_res = 16'hFFFF;
    end else begin
      u_res = quot;
    end
    // quotient minus 90, clamped to -90..90; zero when the tilt limits are equal
    if (zden_q) begin
      t_res = 8'd0;
    end else if (neg_q) begin
      t_res = 8'(-90);
    end else if (div_ovf || quot >= 16'd180) begin
      t_res = 8'd90;
    end else begin
      t_res = 8'(quot[7:0] - 8'd90);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_store) begin
      case (cmd.op)
        pea_pkg::OP_POS_X:  calc_x   <= u_res;
        pea_pkg::OP_POS_Y:  calc_y   <= u_res;
        pea_pkg::OP_PRES:   pressure <= u_res;
        pea_pkg::OP_TILT_X: tilt_x   <= t_res;
        default:            tilt_y   <= t_res;
      endcase
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_x    <= pea_pkg::RST_MAX_X;
      max_y    <= pea_pkg::RST_MAX_Y;
      max_pres <= pea_pkg::RST_MAX_PRES;
      tmin_x   <= pea_pkg::RST_TILT_MIN;
      tmax_x   <= pea_pkg::RST_TILT_MAX;
      tmin_y   <= pea_pkg::RST_TILT_MIN;
      tmax_y   <= pea_pkg::RST_TILT_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pea_pkg::REG_MAX_X:      max_x    <= cfg_data;
        pea_pkg::REG_MAX_Y:      max_y    <= cfg_data;
        pea_pkg::REG_MAX_PRES:   max_pres <= cfg_data;
        pea_pkg::REG_TILT_MIN_X: tmin_x   <= cfg_data;
        pea_pkg::REG_TILT_MAX_X: tmax_x   <= cfg_data;
        pea_pkg::REG_TILT_MIN_Y: tmin_y   <= cfg_data;
        pea_pkg::REG_TILT_MAX_Y: tmax_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // event state
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_x     <= '0;
      raw_y     <= '0;
      raw_pres  <= '0;
      raw_tx    <= '0;
      raw_ty    <= '0;
      touching  <= 1'b0;
      tool_now  <= pea_pkg::TOOL_NONE;
      prev_type <= pea_pkg::PREV_TYPE_RST;
    end else if (cmd.ev_latch) begin
      prev_type <= ev_type;
      if (ev_type == pea_pkg::EV_ABS) begin
        case (ev_code)
          pea_pkg::CODE_X:        raw_x    <= ev_value;
          pea_pkg::CODE_Y:        raw_y    <= ev_value;
          pea_pkg::CODE_PRESSURE: raw_pres <= ev_value;
          pea_pkg::CODE_TILT_X:   raw_tx   <= ev_value;
          pea_pkg::CODE_TILT_Y:   raw_ty   <= ev_value;
          default: ;
        endcase
      end else if (ev_type == pea_pkg::EV_KEY) begin
        case (ev_code)
          pea_pkg::CODE_TOUCH: touching <= ev_value != 32'd0;
          pea_pkg::CODE_PEN:
            tool_now <= (ev_value != 32'd0) ? pea_pkg::TOOL_PEN : pea_pkg::TOOL_NONE;
          pea_pkg::CODE_ERASER:
            tool_now <= (ev_value != 32'd0) ? pea_pkg::TOOL_ERASER : pea_pkg::TOOL_NONE;
          default: ;
        endcase
      end
    end
  end

  // report bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_down  <= 1'b0;
      rep_tool  <= pea_pkg::TOOL_NONE;
      rep_pos_x <= '0;
      rep_pos_y <= '0;
      has_enter <= 1'b0;
      has_leave <= 1'b0;
      releasing <= 1'b0;
      mid_kind  <= pea_pkg::KIND_MOVE;
    end else begin
      if (cmd.rep_start) begin
        has_enter <= (rep_tool == pea_pkg::TOOL_NONE) && (tool_now != pea_pkg::TOOL_NONE);
        has_leave <= (rep_tool != pea_pkg::TOOL_NONE) && (tool_now == pea_pkg::TOOL_NONE);
        releasing <= !touching && rep_down;
        if (touching && !rep_down) begin
          mid_kind <= pea_pkg::KIND_PRESS;
        end else if (!touching && rep_down) begin
          mid_kind <= pea_pkg::KIND_RELEASE;
        end else begin
          mid_kind <= pea_pkg::KIND_MOVE;
        end
      end
      if (cmd.rep_commit) begin
        rep_down <= touching;
        rep_tool <= tool_now;
        if (!releasing) begin
          rep_pos_x <= calc_x;
          rep_pos_y <= calc_y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_commit) begin
      pos_x       <= releasing ? rep_pos_x : calc_x;
      pos_y       <= releasing ? rep_pos_y : calc_y;
      pointer     <= releasing ? rep_tool : tool_now;
      button_down <= touching;
    end
  end

  assign status.is_report = (ev_type == pea_pkg::EV_SYN) && (ev_code == pea_pkg::CODE_REPORT)
                            && (prev_type != pea_pkg::EV_SYN);
  assign status.div_done  = div_done;
  assign status.has_enter = has_enter;
  assign status.has_leave = has_leave;
  assign status.mid_kind  = mid_kind;

endmodule

>>> hw/rtl/pea_ctrl.sv
// ----------------------------------------------------------------------------
// pea_ctrl
// sequencer: event intake, five scaling passes, result beats
// ----------------------------------------------------------------------------
module pea_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            kind,
  output logic                  last,
  output pea_pkg::ctrl_cmd_t    cmd,
  input  pea_pkg::ctrl_status_t status
);

  pea_pkg::state_t state, state_next;
  logic [2:0]      op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pea_pkg::ST_IDLE;
      op    <= pea_pkg::OP_POS_X;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    kind       = pea_pkg::KIND_MOVE;
    last       = 1'b0;
    unique case (state)
      pea_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ev_latch = 1'b1;
          if (status.is_report) begin
            cmd.rep_start = 1'b1;
            op_next       = pea_pkg::OP_POS_X;
            state_next    = pea_pkg::ST_MUL;
          end
        end
      end
      pea_pkg::ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = pea_pkg::ST_DIV_START;
      end
      pea_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = pea_pkg::ST_DIV_WAIT;
      end
      pea_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.res_store = 1'b1;
          if (op == pea_pkg::OP_TILT_Y) begin
            state_next = pea_pkg::ST_COMMIT;
          end else begin
            op_next    = op + 3'd1;
            state_next = pea_pkg::ST_MUL;
          end
        end
      end
      pea_pkg::ST_COMMIT: begin
        cmd.rep_commit = 1'b1;
        state_next = status.has_enter ? pea_pkg::ST_EMIT_ENTER : pea_pkg::ST_EMIT_MID;
      end
      pea_pkg::ST_EMIT_ENTER: begin
        out_valid = 1'b1;
        kind      = pea_pkg::KIND_ENTER;
        if (out_ready) begin
          state_next = pea_pkg::ST_EMIT_MID;
        end
      end
      pea_pkg::ST_EMIT_MID: begin
        out_valid = 1'b1;
        kind      = status.mid_kind;
        last      = !status.has_leave;
        if (out_ready) begin
          state_next = status.has_leave ? pea_pkg::ST_EMIT_LEAVE : pea_pkg::ST_IDLE;
        end
      end
      pea_pkg::ST_EMIT_LEAVE: begin
        out_valid = 1'b1;
        kind      = pea_pkg::KIND_LEAVE;
        last      = 1'b1;
        if (out_ready) begin
          state_next = pea_pkg::ST_IDLE;
        end
      end
      default: state_next = pea_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the pen event aggregator: random and directed event streams go in,
// a scoreboard predicts every result beat and compares it on arrival
// ----------------------------------------------------------------------------
typedef struct packed {
  logic [2:0]  kind;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [1:0]  pointer;
  logic [15:0] pressure;
  logic [7:0]  tilt_x;
  logic [7:0]  tilt_y;
  logic        button_down;
  logic        last;
} pen_beat_t;

class pen_scoreboard;
  int unsigned  errors;
  pen_beat_t    pending[$];
  // register copies
  logic [15:0]  full_x, full_y, full_pres;
  logic signed [15:0] tmin_x, tmax_x, tmin_y, tmax_y;
  // latched event state
  longint       ax_x, ax_y, ax_pres, ax_tx, ax_ty;
  bit           touch, rep_down;
  logic [1:0]   tool, rep_tool;
  logic [15:0]  rep_x, rep_y;
  logic [4:0]   prev_type;

  function new();
    errors = 0;
    full_x = pea_pkg::RST_MAX_X; full_y = pea_pkg::RST_MAX_Y;
    full_pres = pea_pkg::RST_MAX_PRES;
    tmin_x = pea_pkg::RST_TILT_MIN; tmax_x = pea_pkg::RST_TILT_MAX;
    tmin_y = pea_pkg::RST_TILT_MIN; tmax_y = pea_pkg::RST_TILT_MAX;
    ax_x = 0; ax_y = 0; ax_pres = 0; ax_tx = 0; ax_ty = 0;
    touch = 0; rep_down = 0; tool = pea_pkg::TOOL_NONE; rep_tool = pea_pkg::TOOL_NONE;
    rep_x = 0; rep_y = 0; prev_type = pea_pkg::PREV_TYPE_RST;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      pea_pkg::REG_MAX_X:      full_x = val;
      pea_pkg::REG_MAX_Y:      full_y = val;
      pea_pkg::REG_MAX_PRES:   full_pres = val;
      pea_pkg::REG_TILT_MIN_X: tmin_x = val;
      pea_pkg::REG_TILT_MAX_X: tmax_x = val;
      pea_pkg::REG_TILT_MIN_Y: tmin_y = val;
      pea_pkg::REG_TILT_MAX_Y: tmax_y = val;
      default: ;
    endcase
  endfunction

  function logic [15:0] scale(longint raw, longint mult, logic [15:0] full);
    longint d, q;
    d = (full == 0) ? 1 : full;
    if (raw <= 0) return 0;
    q = raw * mult / d;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function logic [7:0] tilt(longint v, logic signed [15:0] lo, logic signed [15:0] hi);
    longint den, r;
    den = longint'(hi) - longint'(lo);
    if (den == 0) return 0;
    r = (v - longint'(lo)) * 180 / den - 90;
    if (r < -90) r = -90;
    if (r > 90) r = 90;
    return r[7:0];
  endfunction

  function void note_event(logic [4:0] etype, logic [9:0] code, logic signed [31:0] val);
    pen_beat_t b;
    logic [2:0] kinds[3];
    int n;
    bit releasing;
    if (etype == pea_pkg::EV_ABS) begin
      case (code)
        pea_pkg::CODE_X:        ax_x = val;
        pea_pkg::CODE_Y:        ax_y = val;
        pea_pkg::CODE_PRESSURE: ax_pres = val;
        pea_pkg::CODE_TILT_X:   ax_tx = val;
        pea_pkg::CODE_TILT_Y:   ax_ty = val;
        default: ;
      endcase
    end else if (etype == pea_pkg::EV_KEY) begin
      case (code)
        pea_pkg::CODE_TOUCH:  touch = (val != 0);
        pea_pkg::CODE_PEN:    tool = (val != 0) ? pea_pkg::TOOL_PEN : pea_pkg::TOOL_NONE;
        pea_pkg::CODE_ERASER: tool = (val != 0) ? pea_pkg::TOOL_ERASER : pea_pkg::TOOL_NONE;
        default: ;
      endcase
    end else if (etype == pea_pkg::EV_SYN && code == pea_pkg::CODE_REPORT &&
                 prev_type != pea_pkg::EV_SYN) begin
      b.pos_x = scale(ax_x, pea_pkg::DEF_SCREEN_WIDTH * 16, full_x);
      b.pos_y = scale(ax_y, pea_pkg::DEF_SCREEN_HEIGHT * 16, full_y);
      b.pressure = scale(ax_pres, 65536, full_pres);
      b.tilt_x = tilt(ax_ty, tmin_y, tmax_y);
      b.tilt_y = tilt(ax_tx, tmin_x, tmax_x);
      b.pointer = tool;
      b.button_down = touch;
      releasing = !touch && rep_down;
      if (releasing) begin
        b.pos_x = rep_x; b.pos_y = rep_y; b.pointer = rep_tool;
      end
      n = 0;
      if (rep_tool == pea_pkg::TOOL_NONE && tool != pea_pkg::TOOL_NONE) begin
        kinds[n] = pea_pkg::KIND_ENTER;
        n = n + 1;
      end
      if (touch && !rep_down) kinds[n] = pea_pkg::KIND_PRESS;
      else if (releasing) kinds[n] = pea_pkg::KIND_RELEASE;
      else kinds[n] = pea_pkg::KIND_MOVE;
      n = n + 1;
      if (rep_tool != pea_pkg::TOOL_NONE && tool == pea_pkg::TOOL_NONE) begin
        kinds[n] = pea_pkg::KIND_LEAVE;
        n = n + 1;
      end
      for (int k = 0; k < n; k++) begin
        b.kind = kinds[k];
        b.last = (k == n - 1);
        pending.push_back(b);
      end
      rep_down = touch; rep_tool = tool; rep_x = b.pos_x; rep_y = b.pos_y;
    end
    prev_type = etype;
  endfunction

  function void check_beat(pen_beat_t got);
    pen_beat_t e;
    if (pending.size() == 0) begin
      $error("unexpected result beat kind=%0d", got.kind);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.kind != got.kind) begin $error("kind exp %0d got %0d", e.kind, got.kind); errors++; end
    if (e.pos_x != got.pos_x) begin $error("pos_x exp %0d got %0d", e.pos_x, got.pos_x); errors++; end
    if (e.pos_y != got.pos_y) begin $error("pos_y exp %0d got %0d", e.pos_y, got.pos_y); errors++; end
    if (e.pointer != got.pointer) begin
      $error("pointer exp %0d got %0d", e.pointer, got.pointer); errors++;
    end
    if (e.pressure != got.pressure) begin
      $error("pressure exp %0d got %0d", e.pressure, got.pressure); errors++;
    end
    if (e.tilt_x != got.tilt_x) begin
      $error("tilt_x exp %0d got %0d", $signed(e.tilt_x), $signed(got.tilt_x)); errors++;
    end
    if (e.tilt_y != got.tilt_y) begin
      $error("tilt_y exp %0d got %0d", $signed(e.tilt_y), $signed(got.tilt_y)); errors++;
    end
    if (e.button_down != got.button_down) begin
      $error("button_down exp %0d got %0d", e.button_down, got.button_down); errors++;
    end
    if (e.last != got.last) begin $error("last exp %0d got %0d", e.last, got.last); errors++; end
  endfunction
endclass

module tb_top;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [4:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pen_scoreboard pen_sb = new();
  bit          hold_off = 0;   // long receiver stall, driven by the stimulus
  bit          stim_done = 0;

  pen_event_aggregator uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random per-beat wait, plus the long hold-off window
  initial begin
    int gap;
    pen_beat_t got;
    forever begin
      gap = $urandom_range(0, 4);
      if (gap != 0 || hold_off) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      // beat taken at this edge
      got.kind = m_axis_tuser;
      got.pos_x = m_axis_tdata[15:0];
      got.pos_y = m_axis_tdata[31:16];
      got.pointer = m_axis_tdata[33:32];
      got.pressure = m_axis_tdata[49:34];
      got.tilt_x = m_axis_tdata[57:50];
      got.tilt_y = m_axis_tdata[65:58];
      got.button_down = m_axis_tdata[66];
      got.last = m_axis_tlast;
      pen_sb.check_beat(got);
    end
  end

  // one event beat, with a random idle gap in front
  task automatic send_event(logic [4:0] etype, logic [9:0] code, logic [31:0] val);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= etype;
    s_axis_tdata <= {6'd0, val, code};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pen_sb.note_event(etype, code, val);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pen_sb.write_reg(idx, val);
  endtask

  // wait for every expected beat, then let the divider settle
  task automatic drain();
    s_axis_tvalid <= 0;
    while (pen_sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic load_regs(logic [15:0] mx, logic [15:0] my, logic [15:0] mp,
                           logic [15:0] lx, logic [15:0] hx, logic [15:0] ly,
                           logic [15:0] hy);
    write_reg(pea_pkg::REG_MAX_X, mx);
    write_reg(pea_pkg::REG_MAX_Y, my);
    write_reg(pea_pkg::REG_MAX_PRES, mp);
    write_reg(pea_pkg::REG_TILT_MIN_X, lx);
    write_reg(pea_pkg::REG_TILT_MAX_X, hx);
    write_reg(pea_pkg::REG_TILT_MIN_Y, ly);
    write_reg(pea_pkg::REG_TILT_MAX_Y, hy);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_axis_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      3: return $urandom_range(0, 70000);
      default: return $urandom_range(0, 20000) - 10000;
    endcase
  endfunction

  // a report: one to four axis, key or noise events, then a sync, sometimes repeated
  task automatic random_report();
    int n;
    logic [9:0] axes[5];
    axes = '{pea_pkg::CODE_X, pea_pkg::CODE_Y, pea_pkg::CODE_PRESSURE,
             pea_pkg::CODE_TILT_X, pea_pkg::CODE_TILT_Y};
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: send_event(pea_pkg::EV_KEY, pea_pkg::CODE_TOUCH,
                      $urandom_range(0, 1) ? $urandom() : 32'd0);
        1: send_event(pea_pkg::EV_KEY,
                      $urandom_range(0, 1) ? pea_pkg::CODE_PEN : pea_pkg::CODE_ERASER,
                      $urandom_range(0, 2) ? 32'd1 : 32'd0);
        2: send_event(5'($urandom()), 10'($urandom()), $urandom());   // noise
        default: send_event(pea_pkg::EV_ABS, axes[$urandom_range(0, 4)], rand_axis_value());
      endcase
    end
    send_event(pea_pkg::EV_SYN, pea_pkg::CODE_REPORT, 0);
    if ($urandom_range(0, 9) == 0) send_event(pea_pkg::EV_SYN, pea_pkg::CODE_REPORT, 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: enter with pen, press, move, release, leave
    send_event(pea_pkg::EV_KEY, pea_pkg::CODE_PEN, 1);
    send_event(pea_pkg::EV_ABS, pea_pkg::CODE_X, 20967);
    send_event(pea_pkg::EV_ABS, pea_pkg::CODE_Y, 32'hFFFF_FFFF);          // negative position
    send_event(pea_pkg::EV_ABS, pea_pkg::CODE_TILT_X, 9000);
    send_event(pea_pkg::EV_ABS, pea_pkg::CODE_TILT_Y, -9000);
    send_event(pea_pkg::EV_SYN, pea_pkg::CODE_REPORT, 0);
    send_event(pea_pkg::EV_KEY, pea_pkg::CODE_TOUCH, 1);
    send_event(pea_pkg::EV_ABS, pea_pkg::CODE_PRESSURE, 32'h7FFF_FFFF);   // saturated pressure
    send_event(pea_pkg::EV_SYN, pea_pkg::CODE_REPORT, 0);
    send_event(pea_pkg::EV_SYN, pea_pkg::CODE_REPORT, 0);                 // repeated sync
    send_event(pea_pkg::EV_ABS, pea_pkg::CODE_X, 32'h8000_0000);
    send_event(5'd31, 10'h3FF, 32'hFFFF_FFFF);                            // unknown event
    send_event(pea_pkg::EV_SYN, pea_pkg::CODE_REPORT, 0);
    send_event(pea_pkg::EV_KEY, pea_pkg::CODE_TOUCH, 0);
    send_event(pea_pkg::EV_ABS, pea_pkg::CODE_X, 5000);     // release keeps old position
    send_event(pea_pkg::EV_SYN, pea_pkg::CODE_REPORT, 0);
    send_event(pea_pkg::EV_KEY, pea_pkg::CODE_ERASER, 1);
    send_event(pea_pkg::EV_SYN, pea_pkg::CODE_REPORT, 0);
    send_event(pea_pkg::EV_KEY, pea_pkg::CODE_PEN, 0);      // any tool key clears tool
    send_event(pea_pkg::EV_SYN, pea_pkg::CODE_REPORT, 1);
    send_event(pea_pkg::EV_SYN, 10'd5, 0);                  // sync with another code
    drain();

    // extremes: zero full scale, equal tilt limits, widest tilt range
    load_regs(16'd0, 16'd1, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    send_event(pea_pkg::EV_KEY, pea_pkg::CODE_TOUCH, 1);
    send_event(pea_pkg::EV_ABS, pea_pkg::CODE_TILT_Y, 32'hFFFF_0000);
    send_event(pea_pkg::EV_ABS, pea_pkg::CODE_PRESSURE, 1);
    send_event(pea_pkg::EV_SYN, pea_pkg::CODE_REPORT, 0);

    // long receiver stall while events keep coming
    hold_off = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) random_report();
    join
    drain();

    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd100, 16'd100);
    for (int i = 0; i < 8; i++) random_report();
    drain();

    load_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 65535)), 16'($urandom()), 16'($urandom()),
              16'($urandom()), 16'($urandom()));
    for (int i = 0; i < 8; i++) random_report();
    drain();

    load_regs(pea_pkg::RST_MAX_X, pea_pkg::RST_MAX_Y, pea_pkg::RST_MAX_PRES,
              pea_pkg::RST_TILT_MIN, pea_pkg::RST_TILT_MAX,
              pea_pkg::RST_TILT_MIN, pea_pkg::RST_TILT_MAX);
    for (int i = 0; i < 7; i++) random_report();
    drain();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (pen_sb.errors == 0 && pen_sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule

>>> files.f
hw/rtl/pea_pkg.sv
hw/rtl/pea_div.sv
hw/rtl/pea_datapath.sv
hw/rtl/pea_ctrl.sv
hw/rtl/pen_event_aggregator.sv
tb/tb_top.sv
